### hw/rtl/mai_pkg.sv
// Shared types and codes for the machine alarm interlock
`timescale 1ns / 1ps

package mai_pkg;

    // Default depth of the queue between the front and the back part
    localparam int unsigned QUEUE_DEPTH = 2;

    // Decoded transaction kind
    typedef enum logic [1:0] {
        CMD_POLL  = 2'd0,
        CMD_FAIL  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_NOP   = 2'd3
    } mai_cmd_t;

    // Highest-priority active alarm cause below power loss
    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_WIRE  = 2'd1,
        CAUSE_ALARM = 2'd2,
        CAUSE_SOFT  = 2'd3
    } mai_cause_t;

    // Interlock state, one-hot
    typedef enum logic [7:0] {
        ST_POWER    = 8'b0000_0001,
        ST_WIRE     = 8'b0000_0010,
        ST_ALARM    = 8'b0000_0100,
        ST_SOFT     = 8'b0000_1000,
        ST_EXIT     = 8'b0001_0000,
        ST_NORMAL   = 8'b0010_0000,
        ST_DRUM     = 8'b0100_0000,
        ST_DRUM_ERR = 8'b1000_0000
    } mai_state_t;

    // Reported state codes
    localparam logic [2:0] CODE_POWER    = 3'd0;
    localparam logic [2:0] CODE_WIRE     = 3'd1;
    localparam logic [2:0] CODE_ALARM    = 3'd2;
    localparam logic [2:0] CODE_SOFT     = 3'd3;
    localparam logic [2:0] CODE_EXIT     = 3'd4;
    localparam logic [2:0] CODE_NORMAL   = 3'd5;
    localparam logic [2:0] CODE_DRUM     = 3'd6;
    localparam logic [2:0] CODE_DRUM_ERR = 3'd7;

    // Notify codes
    localparam logic [1:0] NOTIFY_NONE    = 2'd0;
    localparam logic [1:0] NOTIFY_FAILURE = 2'd1;
    localparam logic [1:0] NOTIFY_ALARM   = 2'd2;

    // Gap regulator codes
    localparam logic [1:0] REG_NONE  = 2'd0;
    localparam logic [1:0] REG_CLEAR = 2'd1;
    localparam logic [1:0] REG_STOP  = 2'd2;

    // Drum command codes
    localparam logic [2:0] DRUM_NONE      = 3'd0;
    localparam logic [2:0] DRUM_DISABLE   = 3'd1;
    localparam logic [2:0] DRUM_FWD_APPLY = 3'd2;
    localparam logic [2:0] DRUM_REV_APPLY = 3'd3;
    localparam logic [2:0] DRUM_FWD_REG   = 3'd4;
    localparam logic [2:0] DRUM_REV_REG   = 3'd5;

    // Restore codes
    localparam logic [1:0] RESTORE_NONE  = 2'd0;
    localparam logic [1:0] RESTORE_PLAIN = 2'd1;
    localparam logic [1:0] RESTORE_APPLY = 2'd2;

    // Drum direction codes on the input
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    // Classified transaction handed from the front to the back part
    typedef struct packed {
        mai_cmd_t   cmd;
        logic       power;
        mai_cause_t cause;
        logic       any_flag;
        logic       fwd;
        logic       rev;
        logic       conflict_enter;  // switch disagrees with direction on entry
        logic       conflict_hold;   // switch disagrees with direction in drum state
        logic [2:0] reapply_cmd;     // drum command that re-applies the direction
        logic       drum_enabled;
        logic       direct_mode;
        logic       idle_stopped;
    } mai_item_t;

endpackage

### hw/rtl/mai_if.sv
// Handshake interfaces for the poll and result channels
`timescale 1ns / 1ps

interface mai_poll_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       lim_power;
    logic       lim_wire;
    logic       lim_alarm;
    logic       lim_soft;
    logic       lim_fwd;
    logic       lim_rev;
    logic [1:0] drum_dir;
    logic       drum_enabled;
    logic       direct_mode;
    logic       idle_stopped;

    modport source (
        output valid, action, lim_power, lim_wire, lim_alarm, lim_soft,
               lim_fwd, lim_rev, drum_dir, drum_enabled, direct_mode, idle_stopped,
        input  ready
    );
    modport sink (
        input  valid, action, lim_power, lim_wire, lim_alarm, lim_soft,
               lim_fwd, lim_rev, drum_dir, drum_enabled, direct_mode, idle_stopped,
        output ready
    );
endinterface

interface mai_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] alarm_state;
    logic       alarm_active;
    logic       drum_permit;
    logic       reset_speed;
    logic [1:0] notify;
    logic [1:0] regulator_cmd;
    logic       exit_direct;
    logic       stop_request;
    logic [2:0] drum_command;
    logic [1:0] restore_outputs;
    logic       snapshot_outputs;
    logic       clear_soft_alarm;

    modport source (
        output valid, alarm_state, alarm_active, drum_permit, reset_speed, notify,
               regulator_cmd, exit_direct, stop_request, drum_command,
               restore_outputs, snapshot_outputs, clear_soft_alarm,
        input  ready
    );
    modport sink (
        input  valid, alarm_state, alarm_active, drum_permit, reset_speed, notify,
               regulator_cmd, exit_direct, stop_request, drum_command,
               restore_outputs, snapshot_outputs, clear_soft_alarm,
        output ready
    );
endinterface

### hw/rtl/mai_front.sv
// Front part: accepts poll transactions and classifies them into items
`timescale 1ns / 1ps

module mai_front
    import mai_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    mai_poll_if.sink        poll,
    output logic            item_valid,
    output mai_item_t       item,
    input  logic            item_ready
);

    logic      valid_reg;
    logic      valid_next;
    mai_item_t item_reg;
    mai_item_t item_next;
    logic      take;

    // Stage register frees up as soon as the queue takes its item
    assign poll.ready = !valid_reg || item_ready;
    assign take       = poll.valid && poll.ready;

    // Classification of one poll transaction
    always_comb
    begin
        item_next = item_reg;
        if (take)
        begin
            case (poll.action)
                CMD_POLL:  item_next.cmd = CMD_POLL;
                CMD_FAIL:  item_next.cmd = CMD_FAIL;
                CMD_RESET: item_next.cmd = CMD_RESET;
                default:   item_next.cmd = CMD_NOP;
            endcase
            item_next.power = poll.lim_power;
            if (poll.lim_wire)
                item_next.cause = CAUSE_WIRE;
            else if (poll.lim_alarm)
                item_next.cause = CAUSE_ALARM;
            else if (poll.lim_soft)
                item_next.cause = CAUSE_SOFT;
            else
                item_next.cause = CAUSE_NONE;
            item_next.any_flag = poll.lim_power | poll.lim_wire | poll.lim_alarm |
                                 poll.lim_soft | poll.lim_fwd | poll.lim_rev;
            item_next.fwd = poll.lim_fwd;
            item_next.rev = poll.lim_rev;
            item_next.conflict_enter = (poll.lim_fwd && poll.lim_rev) ||
                                       (poll.drum_dir == DIR_FWD && poll.lim_rev) ||
                                       (poll.drum_dir == DIR_REV && poll.lim_fwd);
            item_next.conflict_hold  = (poll.lim_fwd && poll.lim_rev) ||
                                       (poll.drum_dir == DIR_FWD && poll.lim_fwd) ||
                                       (poll.drum_dir == DIR_REV && poll.lim_rev);
            if (poll.drum_dir == DIR_FWD)
                item_next.reapply_cmd = DRUM_FWD_APPLY;
            else if (poll.drum_dir == DIR_REV)
                item_next.reapply_cmd = DRUM_REV_APPLY;
            else
                item_next.reapply_cmd = DRUM_DISABLE;
            item_next.drum_enabled = poll.drum_enabled;
            item_next.direct_mode  = poll.direct_mode;
            item_next.idle_stopped = poll.idle_stopped;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (item_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hw/rtl/mai_queue.sv
// Short queue of classified items between the front and the back part
`timescale 1ns / 1ps

module mai_queue
    import mai_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    input  mai_item_t wr_item,
    output logic      wr_ready,
    output logic      rd_valid,
    output mai_item_t rd_item,
    input  logic      rd_ready
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mai_item_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

### hw/rtl/mai_back.sv
// Back part: interlock state machine and registered result stage
`timescale 1ns / 1ps

module mai_back
    import mai_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  mai_item_t   item,
    output logic        item_ready,
    mai_result_if.source result
);

    mai_state_t state_reg;
    mai_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       take;

    logic       reset_speed;
    logic [1:0] notify;
    logic [1:0] regulator_cmd;
    logic       exit_direct;
    logic       stop_request;
    logic [2:0] drum_command;
    logic [1:0] restore_outputs;
    logic       snapshot_outputs;
    logic       clear_soft_alarm;
    logic [2:0] state_code;

    logic [2:0] alarm_state_reg;
    logic       alarm_active_reg;
    logic       drum_permit_reg;
    logic       reset_speed_reg;
    logic [1:0] notify_reg;
    logic [1:0] regulator_cmd_reg;
    logic       exit_direct_reg;
    logic       stop_request_reg;
    logic [2:0] drum_command_reg;
    logic [1:0] restore_outputs_reg;
    logic       snapshot_outputs_reg;
    logic       clear_soft_alarm_reg;

    // A new item is taken whenever the result register is empty or draining
    assign item_ready = !out_valid_reg || result.ready;
    assign take       = item_valid && item_ready;

    // Next state and command strobes
    always_comb
    begin
        state_next       = state_reg;
        reset_speed      = 1'b0;
        notify           = NOTIFY_NONE;
        regulator_cmd    = REG_NONE;
        exit_direct      = 1'b0;
        stop_request     = 1'b0;
        drum_command     = DRUM_NONE;
        restore_outputs  = RESTORE_NONE;
        snapshot_outputs = 1'b0;
        clear_soft_alarm = 1'b0;
        case (item.cmd)
            CMD_FAIL:  state_next = ST_POWER;
            CMD_RESET: state_next = ST_NORMAL;
            CMD_POLL:
            begin
                reset_speed = item.any_flag;
                if (item.power)
                begin
                    if (state_reg != ST_POWER)
                    begin
                        notify        = NOTIFY_FAILURE;
                        regulator_cmd = REG_CLEAR;
                    end
                    state_next = ST_POWER;
                end
                else if (item.cause != CAUSE_NONE)
                begin
                    exit_direct   = item.direct_mode;
                    regulator_cmd = REG_CLEAR;
                    if (state_reg == ST_NORMAL || state_reg == ST_DRUM ||
                        state_reg == ST_DRUM_ERR)
                        notify = NOTIFY_ALARM;
                    case (item.cause)
                        CAUSE_WIRE:  state_next = ST_WIRE;
                        CAUSE_ALARM: state_next = ST_ALARM;
                        default:     state_next = ST_SOFT;
                    endcase
                end
                else
                begin
                    case (state_reg)
                        ST_POWER, ST_WIRE, ST_ALARM:
                            state_next = ST_EXIT;
                        ST_SOFT:
                        begin
                            if (item.idle_stopped)
                            begin
                                state_next       = ST_EXIT;
                                clear_soft_alarm = 1'b1;
                            end
                        end
                        ST_EXIT, ST_NORMAL:
                        begin
                            if (state_reg == ST_EXIT)
                            begin
                                state_next      = ST_NORMAL;
                                restore_outputs = item.any_flag ? RESTORE_PLAIN
                                                                : RESTORE_APPLY;
                            end
                            // End switch reached: reverse the drum or trip
                            if (item.fwd || item.rev)
                            begin
                                snapshot_outputs = 1'b1;
                                regulator_cmd    = REG_STOP;
                                reset_speed      = 1'b1;
                                if (item.conflict_enter)
                                begin
                                    stop_request = 1'b1;
                                    drum_command = DRUM_DISABLE;
                                    state_next   = ST_DRUM_ERR;
                                end
                                else if (item.fwd)
                                begin
                                    drum_command = item.drum_enabled ? DRUM_REV_APPLY
                                                                     : DRUM_REV_REG;
                                    state_next   = ST_DRUM;
                                end
                                else
                                begin
                                    drum_command = item.drum_enabled ? DRUM_FWD_APPLY
                                                                     : DRUM_FWD_REG;
                                    state_next   = ST_DRUM;
                                end
                            end
                        end
                        ST_DRUM, ST_DRUM_ERR:
                        begin
                            if (!item.fwd && !item.rev)
                            begin
                                state_next       = ST_NORMAL;
                                restore_outputs  = RESTORE_PLAIN;
                                drum_command     = item.reapply_cmd;
                                clear_soft_alarm = 1'b1;
                            end
                            else if (item.conflict_hold)
                            begin
                                stop_request = 1'b1;
                                drum_command = DRUM_DISABLE;
                                state_next   = ST_DRUM_ERR;
                            end
                        end
                        default:
                            state_next = state_reg;
                    endcase
                end
            end
            default:
                state_next = state_reg;
        endcase
    end

    // State code reported with the result
    always_comb
    begin
        case (state_next)
            ST_POWER:    state_code = CODE_POWER;
            ST_WIRE:     state_code = CODE_WIRE;
            ST_ALARM:    state_code = CODE_ALARM;
            ST_SOFT:     state_code = CODE_SOFT;
            ST_EXIT:     state_code = CODE_EXIT;
            ST_NORMAL:   state_code = CODE_NORMAL;
            ST_DRUM:     state_code = CODE_DRUM;
            default:     state_code = CODE_DRUM_ERR;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_NORMAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
                state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            alarm_state_reg      <= state_code;
            alarm_active_reg     <= !(state_next == ST_NORMAL || state_next == ST_DRUM);
            drum_permit_reg      <= (state_next == ST_NORMAL || state_next == ST_DRUM);
            reset_speed_reg      <= reset_speed;
            notify_reg           <= notify;
            regulator_cmd_reg    <= regulator_cmd;
            exit_direct_reg      <= exit_direct;
            stop_request_reg     <= stop_request;
            drum_command_reg     <= drum_command;
            restore_outputs_reg  <= restore_outputs;
            snapshot_outputs_reg <= snapshot_outputs;
            clear_soft_alarm_reg <= clear_soft_alarm;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.alarm_state      = alarm_state_reg;
    assign result.alarm_active     = alarm_active_reg;
    assign result.drum_permit      = drum_permit_reg;
    assign result.reset_speed      = reset_speed_reg;
    assign result.notify           = notify_reg;
    assign result.regulator_cmd    = regulator_cmd_reg;
    assign result.exit_direct      = exit_direct_reg;
    assign result.stop_request     = stop_request_reg;
    assign result.drum_command     = drum_command_reg;
    assign result.restore_outputs  = restore_outputs_reg;
    assign result.snapshot_outputs = snapshot_outputs_reg;
    assign result.clear_soft_alarm = clear_soft_alarm_reg;

endmodule

### hw/rtl/machine_alarm_interlock_fsm_core.sv
// Top level of the machine alarm and drum limit interlock
//
//   Channel  Dir  Handshake      Payload
//   poll     in   valid / ready  action, six switch flags, drum_dir, drum status
//   result   out  valid / ready  state, status and command strobes
//
// One transaction per clock sustained while the result is taken; a poll passes
// through the front register, the queue and the result register before its result appears.
// The state register in the back part is the only state-machine loop.
// Reset (rst_n low, asynchronous) puts the interlock in the normal state and
// empties the front register, queue and result register.
// A stalled result holds; the front keeps accepting until the queue fills.
`timescale 1ns / 1ps

module machine_alarm_interlock_fsm_core
    import mai_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    mai_poll_if.sink      poll,
    mai_result_if.source  result
);

    logic      front_valid;
    mai_item_t front_item;
    logic      front_ready;
    logic      back_valid;
    mai_item_t back_item;
    logic      back_ready;

    // Accept and classify
    mai_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .poll       (poll),
        .item_valid (front_valid),
        .item       (front_item),
        .item_ready (front_ready)
    );

    // Decoupling queue
    mai_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_item  (front_item),
        .wr_ready (front_ready),
        .rd_valid (back_valid),
        .rd_item  (back_item),
        .rd_ready (back_ready)
    );

    // State machine and result stage
    mai_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (back_valid),
        .item       (back_item),
        .item_ready (back_ready),
        .result     (result)
    );

endmodule

### hw/rtl/mai_checker.sv
// Port-level checks on the interlock result channel, bound to the top level
`timescale 1ns / 1ps

module mai_checker
    import mai_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] alarm_state,
    input logic       alarm_active,
    input logic       drum_permit,
    input logic       reset_speed,
    input logic [1:0] notify,
    input logic       stop_request,
    input logic [2:0] drum_command,
    input logic       clear_soft_alarm
);

    // A stalled result keeps its state field
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(alarm_state))
        else $error("result state changed while stalled");

    // Status flags are complementary
    a_status_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (alarm_active != drum_permit))
        else $error("alarm_active and drum_permit disagree");

    // A stop request comes only with a drum error and a drum disable
    a_stop_drum_err: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && stop_request |->
            (alarm_state == CODE_DRUM_ERR) && (drum_command == DRUM_DISABLE))
        else $error("stop request without drum error");

    // A notification needs at least one flag set
    a_notify_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (notify != NOTIFY_NONE) |-> reset_speed)
        else $error("notification without a flag");

    // Soft alarm is cleared only on the way back to normal
    a_clear_soft: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && clear_soft_alarm |->
            (alarm_state == CODE_EXIT) || (alarm_state == CODE_NORMAL))
        else $error("soft alarm cleared in wrong state");

endmodule

bind machine_alarm_interlock_fsm_core mai_checker u_mai_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .alarm_state      (result.alarm_state),
    .alarm_active     (result.alarm_active),
    .drum_permit      (result.drum_permit),
    .reset_speed      (result.reset_speed),
    .notify           (result.notify),
    .stop_request     (result.stop_request),
    .drum_command     (result.drum_command),
    .clear_soft_alarm (result.clear_soft_alarm)
);
